// ===== src/afct_pkg.sv =====
// ----------------------------------------------------------------------------
// afct_pkg
// Shared constants and types for the aging fault code tables.
// ----------------------------------------------------------------------------
package afct_pkg;

	localparam int SLOTS_PER_TABLE = 15;
	localparam int NUM_TABLES      = 3;

	localparam int CODE_W     = 32;
	localparam int TIMER_W    = 8;
	localparam int TAB_W      = 2;
	localparam int SLOT_IDX_W = 4;
	localparam int COUNT_W    = 5;

	localparam logic [TIMER_W-1:0] HOLD_RESET = TIMER_W'(12);

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [TIMER_W-1:0] timer_t;

	typedef struct packed {
		code_t  code;
		timer_t timer;
	} slot_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_COLLAPSE,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     wrap;
		logic     dec;
	} row_ctl_t;

endpackage

// ===== src/afct_cell.sv =====
// ----------------------------------------------------------------------------
// afct_cell
// One table slot: holds a code and a hold timer, shifts from its right
// neighbor, collapses over holes and takes part in the insert search.
// ----------------------------------------------------------------------------
module afct_cell import afct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  slot_t    nxt,
	input  logic     hole_in,
	input  logic     found_in,
	input  logic     prev_live,
	input  code_t    new_code,
	input  timer_t   hold,
	output slot_t    cur,
	output logic     live,
	output logic     hole_out,
	output logic     found_out
);

	slot_t slot_q;
	logic  match;

	assign cur       = slot_q;
	assign live      = (slot_q.timer != '0);
	assign match     = live && (slot_q.code == new_code);
	assign hole_out  = hole_in || !live;
	assign found_out = found_in || match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			unique case (op)
				CELL_HOLD: begin
				end
				CELL_SHIFT: begin
					slot_q <= nxt;
				end
				CELL_COLLAPSE: begin
					if (hole_out) begin
						slot_q <= nxt;
					end
				end
				CELL_INSERT: begin
					if (!found_in) begin
						if (match) begin
							slot_q.timer <= hold;
						end else if (!live && prev_live) begin
							slot_q.code  <= new_code;
							slot_q.timer <= hold;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/afct_row.sv =====
// ----------------------------------------------------------------------------
// afct_row
// One fault table as a chain of slot cells; the head cell is slot zero.
// ----------------------------------------------------------------------------
module afct_row import afct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  row_ctl_t ctl,
	input  code_t    new_code,
	input  timer_t   hold,
	output slot_t    head,
	output logic     head_live
);

	slot_t cur   [SLOTS_PER_TABLE];
	slot_t nxt   [SLOTS_PER_TABLE];
	logic  live  [SLOTS_PER_TABLE];
	logic  hole  [SLOTS_PER_TABLE+1];
	logic  found [SLOTS_PER_TABLE+1];
	slot_t wrap_slot;

	assign head      = cur[0];
	assign head_live = live[0];
	assign hole[0]   = 1'b0;
	assign found[0]  = 1'b0;

	// tail input: free slot on collapse, head (aged on emit) on rotate
	always_comb begin
		wrap_slot = '0;
		if (ctl.wrap) begin
			wrap_slot = cur[0];
			if (ctl.dec && live[0]) begin
				wrap_slot.timer = cur[0].timer - TIMER_W'(1);
			end
		end
	end

	for (genvar i = 0; i < SLOTS_PER_TABLE; i++) begin : g_cell
		logic prev_live;

		if (i == SLOTS_PER_TABLE - 1) begin : g_tail
			assign nxt[i] = wrap_slot;
		end else begin : g_body
			assign nxt[i] = cur[i+1];
		end

		if (i == 0) begin : g_first
			assign prev_live = 1'b1;
		end else begin : g_rest
			assign prev_live = live[i-1];
		end

		afct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (ctl.op),
			.nxt       (nxt[i]),
			.hole_in   (hole[i]),
			.found_in  (found[i]),
			.prev_live (prev_live),
			.new_code  (new_code),
			.hold      (hold),
			.cur       (cur[i]),
			.live      (live[i]),
			.hole_out  (hole[i+1]),
			.found_out (found[i+1])
		);
	end

endmodule

// ===== src/aging_fault_code_table_top.sv =====
// ----------------------------------------------------------------------------
// aging_fault_code_table_top
// Three aging fault code tables with report, compaction and tick readout.
// ----------------------------------------------------------------------------
// Each table is a chain of 15 slot cells that shift toward slot zero. A report
// runs 14 collapse steps that squeeze free slots out of the chosen table,
// then one insert step that refreshes a matching code or fills the first free
// slot (a zero code skips the insert step; a table out of range is ignored).
// A tick first rotates all tables once and counts the live slots, then gives
// 45 results, one per cycle while the output does not stall, as each table in
// turn rotates through its head cell and its timers age. No new request is
// taken until the current one is done. The hold time resets to 12 and is
// written through the cfg port, which is always ready.
module aging_fault_code_table_top import afct_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TIMER_W-1:0]    cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic [TAB_W-1:0]      table_select,
	input  logic [CODE_W-1:0]     fault_code,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TAB_W-1:0]      table_index,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic [CODE_W-1:0]     slot_code,
	output logic [COUNT_W-1:0]    live_count,
	output logic                  last
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_COLLAPSE = 3'd1;
	localparam logic [2:0] ST_INSERT   = 3'd2;
	localparam logic [2:0] ST_COUNT    = 3'd3;
	localparam logic [2:0] ST_EMIT     = 3'd4;

	localparam logic [SLOT_IDX_W-1:0] STEP_LAST     = SLOT_IDX_W'(SLOTS_PER_TABLE - 1);
	localparam logic [SLOT_IDX_W-1:0] COLLAPSE_LAST = SLOT_IDX_W'(SLOTS_PER_TABLE - 2);
	localparam logic [TAB_W-1:0]      TAB_LAST      = TAB_W'(NUM_TABLES - 1);
	localparam logic [TAB_W-1:0]      TAB_COUNT     = TAB_W'(NUM_TABLES);

	logic [2:0]            state_q;
	logic [SLOT_IDX_W-1:0] step_q;
	logic [TAB_W-1:0]      tab_q;
	code_t                 code_q;
	timer_t                hold_q;
	logic [COUNT_W-1:0]    cnt_q [NUM_TABLES];

	row_ctl_t ctl       [NUM_TABLES];
	slot_t    head      [NUM_TABLES];
	logic     head_live [NUM_TABLES];

	logic accept;
	logic out_load;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_q <= cfg_data;
		end
	end

	always_comb begin
		for (int t = 0; t < NUM_TABLES; t++) begin
			ctl[t] = '{op: CELL_HOLD, wrap: 1'b0, dec: 1'b0};
			unique case (state_q)
				ST_COLLAPSE: begin
					if (tab_q == TAB_W'(t)) begin
						ctl[t].op = CELL_COLLAPSE;
					end
				end
				ST_INSERT: begin
					if (tab_q == TAB_W'(t)) begin
						ctl[t].op = CELL_INSERT;
					end
				end
				ST_COUNT: begin
					ctl[t] = '{op: CELL_SHIFT, wrap: 1'b1, dec: 1'b0};
				end
				ST_EMIT: begin
					if (tab_q == TAB_W'(t) && out_load) begin
						ctl[t] = '{op: CELL_SHIFT, wrap: 1'b1, dec: 1'b1};
					end
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar t = 0; t < NUM_TABLES; t++) begin : g_row
		afct_row u_row (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[t]),
			.new_code  (code_q),
			.hold      (hold_q),
			.head      (head[t]),
			.head_live (head_live[t])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			tab_q   <= '0;
			for (int t = 0; t < NUM_TABLES; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (func) begin
							state_q <= ST_COUNT;
							for (int t = 0; t < NUM_TABLES; t++) begin
								cnt_q[t] <= '0;
							end
						end else if (table_select < TAB_COUNT) begin
							state_q <= ST_COLLAPSE;
							tab_q   <= table_select;
						end
					end
				end
				ST_COLLAPSE: begin
					step_q <= step_q + SLOT_IDX_W'(1);
					if (step_q == COLLAPSE_LAST) begin
						state_q <= (code_q != '0) ? ST_INSERT : ST_IDLE;
					end
				end
				ST_INSERT: begin
					state_q <= ST_IDLE;
				end
				ST_COUNT: begin
					for (int t = 0; t < NUM_TABLES; t++) begin
						cnt_q[t] <= cnt_q[t] + COUNT_W'(head_live[t]);
					end
					step_q <= step_q + SLOT_IDX_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= ST_EMIT;
						step_q  <= '0;
						tab_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						step_q <= step_q + SLOT_IDX_W'(1);
						if (step_q == STEP_LAST) begin
							step_q <= '0;
							if (tab_q == TAB_LAST) begin
								state_q <= ST_IDLE;
							end else begin
								tab_q <= tab_q + TAB_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= fault_code;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			table_index <= tab_q;
			slot_index  <= step_q;
			slot_code   <= head_live[tab_q] ? head[tab_q].code : '0;
			live_count  <= cnt_q[tab_q];
			last        <= (tab_q == TAB_LAST) && (step_q == STEP_LAST);
		end
	end

endmodule

// ===== src/aging_fault_code_table_chk.sv =====
// ----------------------------------------------------------------------------
// aging_fault_code_table_chk
// Port-level checks for the aging fault code tables, bound to the top level.
// ----------------------------------------------------------------------------
module aging_fault_code_table_chk import afct_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  func,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [TAB_W-1:0]      table_index,
	input logic [SLOT_IDX_W-1:0] slot_index,
	input logic [CODE_W-1:0]     slot_code,
	input logic [COUNT_W-1:0]    live_count,
	input logic                  last
);

	// a tick request keeps the input side busy afterwards
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func) |=> in_stall)
		else $error("tick request did not block the input");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(slot_code)
			&& $stable(slot_index) && $stable(table_index)))
		else $error("stalled result changed");

	// last result is the final slot of the final table
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (table_index == TAB_W'(NUM_TABLES - 1)
			&& slot_index == SLOT_IDX_W'(SLOTS_PER_TABLE - 1)))
		else $error("last flag on wrong slot");

	// results in ranges while a tick is still running
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (in_stall
			&& live_count <= COUNT_W'(SLOTS_PER_TABLE)
			&& slot_index <= SLOT_IDX_W'(SLOTS_PER_TABLE - 1)))
		else $error("result outside a running tick");

endmodule

bind aging_fault_code_table_top aging_fault_code_table_chk u_chk (.*);

// ===== tb/aging_fault_code_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// aging_fault_code_table_top_tb
// Self-checking bench for the three aging fault code tables.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the slot codes, timers and hold
// time, applies every accepted report or tick to it, and queues the 45 slot
// results that each tick must produce. Every result taken from the block is
// compared field by field against the oldest queued one. A directed opening
// covers out-of-range tables, compact-only reports, code extremes, refresh and
// a full table; random phases then run under several hold times, including
// zero and the extremes, with bursty requests, patterned output stalls and one
// long output hold-off that backs the block up.
module aging_fault_code_table_top_tb;
	import afct_pkg::*;

	localparam int TOTAL_SLOTS      = NUM_TABLES * SLOTS_PER_TABLE;
	localparam int RANDOM_ITEMS     = 220;
	localparam int PHASES           = 6;
	localparam int POOL_SIZE        = 32;
	localparam int DRAIN_CYCLES     = 24;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_REPORTED     = 10;
	localparam int RUN_LIMIT        = 2000000;

	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [TAB_W-1:0] TAB_BATTERY = 2'd0;
	localparam logic [TAB_W-1:0] TAB_MOTOR   = 2'd1;
	localparam logic [TAB_W-1:0] TAB_OTHER   = 2'd2;
	localparam logic [TAB_W-1:0] TAB_INVALID = 2'd3;

	typedef struct {
		logic [TAB_W-1:0]      tab;
		logic [SLOT_IDX_W-1:0] slot;
		code_t                 code;
		logic [COUNT_W-1:0]    live;
		logic                  is_last;
	} slot_result_t;

	class fault_table_scoreboard;
		code_t        slot_codes[TOTAL_SLOTS];
		timer_t       slot_timers[TOTAL_SLOTS];
		timer_t       hold;
		slot_result_t expected_q[$];
		int           errors;

		function new();
			foreach (slot_codes[i]) begin
				slot_codes[i]  = '0;
				slot_timers[i] = '0;
			end
			hold   = HOLD_RESET;
			errors = 0;
		endfunction

		function void set_hold(timer_t value);
			hold = value;
		endfunction

		function void compact_table(int base);
			int wr;
			wr = 0;
			for (int rd = 0; rd < SLOTS_PER_TABLE; rd++) begin
				if (slot_timers[base + rd] != '0) begin
					slot_codes[base + wr]  = slot_codes[base + rd];
					slot_timers[base + wr] = slot_timers[base + rd];
					wr++;
				end
			end
			while (wr < SLOTS_PER_TABLE) begin
				slot_codes[base + wr]  = '0;
				slot_timers[base + wr] = '0;
				wr++;
			end
		endfunction

		function void apply_report(logic [TAB_W-1:0] tab, code_t code);
			int base;
			if (int'(tab) >= NUM_TABLES)
				return;
			base = int'(tab) * SLOTS_PER_TABLE;
			compact_table(base);
			if (code == '0)
				return;
			for (int s = 0; s < SLOTS_PER_TABLE; s++) begin
				if (slot_timers[base + s] != '0 && slot_codes[base + s] == code) begin
					slot_timers[base + s] = hold;
					return;
				end
				if (slot_timers[base + s] == '0) begin
					slot_codes[base + s]  = code;
					slot_timers[base + s] = hold;
					return;
				end
			end
		endfunction

		function void apply_tick();
			int           live;
			slot_result_t r;
			for (int t = 0; t < NUM_TABLES; t++) begin
				live = 0;
				for (int s = 0; s < SLOTS_PER_TABLE; s++)
					if (slot_timers[t * SLOTS_PER_TABLE + s] != '0)
						live++;
				for (int s = 0; s < SLOTS_PER_TABLE; s++) begin
					r.tab     = TAB_W'(t);
					r.slot    = SLOT_IDX_W'(s);
					r.code    = (slot_timers[t * SLOTS_PER_TABLE + s] != '0) ?
						slot_codes[t * SLOTS_PER_TABLE + s] : '0;
					r.live    = COUNT_W'(live);
					r.is_last = (t == NUM_TABLES - 1) && (s == SLOTS_PER_TABLE - 1);
					expected_q.push_back(r);
				end
			end
			foreach (slot_timers[i])
				if (slot_timers[i] != '0)
					slot_timers[i] = slot_timers[i] - 1'b1;
		endfunction

		function void note_request(logic req_func, logic [TAB_W-1:0] tab, code_t code);
			if (req_func == FUNC_TICK)
				apply_tick();
			else
				apply_report(tab, code);
		endfunction

		function void check_result(slot_result_t got);
			slot_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTED)
					$display("unexpected result: tab %0d slot %0d code %h live %0d last %0b",
						got.tab, got.slot, got.code, got.live, got.is_last);
				return;
			end
			want = expected_q.pop_front();
			if (got.tab !== want.tab || got.slot !== want.slot || got.code !== want.code ||
					got.live !== want.live || got.is_last !== want.is_last) begin
				errors++;
				if (errors <= MAX_REPORTED) begin
					$display("mismatch: expected tab %0d slot %0d code %h live %0d last %0b",
						want.tab, want.slot, want.code, want.live, want.is_last);
					$display("          actual   tab %0d slot %0d code %h live %0d last %0b",
						got.tab, got.slot, got.code, got.live, got.is_last);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	timer_t                cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  func         = 1'b0;
	logic [TAB_W-1:0]      table_select = '0;
	code_t                 fault_code   = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [TAB_W-1:0]      table_index;
	logic [SLOT_IDX_W-1:0] slot_index;
	code_t                 slot_code;
	logic [COUNT_W-1:0]    live_count;
	logic                  last;

	int                    long_hold_asks = 0;
	slot_result_t          observed;
	fault_table_scoreboard sb = new();

	aging_fault_code_table_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.table_select (table_select),
		.fault_code   (fault_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.table_index  (table_index),
		.slot_index   (slot_index),
		.slot_code    (slot_code),
		.live_count   (live_count),
		.last         (last)
	);

	always #2 clk = ~clk;

	initial begin
		#(RUN_LIMIT);
		$display("aging_fault_code_table_top verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			observed.tab     = table_index;
			observed.slot    = slot_index;
			observed.code    = slot_code;
			observed.live    = live_count;
			observed.is_last = last;
			sb.check_result(observed);
		end
	end

	// output side: stall modes that change over time, plus the long hold-off
	initial begin : result_receiver
		int   mode;
		int   mode_left;
		int   hold_left;
		int   served;
		int   pattern_cnt;
		logic stall_next;
		mode        = 0;
		mode_left   = 0;
		hold_left   = 0;
		served      = 0;
		pattern_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && long_hold_asks != served) begin
				served++;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				pattern_cnt++;
				case (mode)
					0: stall_next = 1'b0;
					1: stall_next = ($urandom_range(0, 99) < 30);
					2: stall_next = ($urandom_range(0, 99) < 75);
					default: stall_next = (pattern_cnt % 3 == 0);
				endcase
			end
			out_stall <= stall_next;
		end
	end

	task automatic send_request(logic req_func, logic [TAB_W-1:0] tab, code_t code);
		@(negedge clk);
		in_valid     <= 1'b1;
		func         <= req_func;
		table_select <= tab;
		fault_code   <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(req_func, tab, code);
	endtask

	task automatic idle_sender(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_hold(timer_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_hold(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item(code_t pool[POOL_SIZE]);
		int               pick;
		int               tab_pick;
		logic [TAB_W-1:0] tab;
		code_t            code;
		pick     = $urandom_range(0, 99);
		tab_pick = $urandom_range(0, 3);
		tab      = (tab_pick < 2) ? TAB_BATTERY : (tab_pick == 2) ? TAB_MOTOR : TAB_OTHER;
		code     = pool[$urandom_range(0, POOL_SIZE - 1)];
		if (pick < 8) begin
			send_request(FUNC_TICK, TAB_W'($urandom), code_t'($urandom));
		end else begin
			if (pick < 14)
				code = '0;
			else if (pick < 18)
				tab = TAB_INVALID;
			else if (pick < 28)
				code = code_t'($urandom);
			send_request(FUNC_REPORT, tab, code);
		end
	endtask

	initial begin : stimulus
		int     burst_left;
		code_t  code_pool[POOL_SIZE];
		timer_t hold_plan[PHASES];
		foreach (code_pool[i])
			code_pool[i] = (i < 4) ? code_t'(i + 1) : code_t'($urandom);
		hold_plan = '{8'd1, 8'd255, 8'd0, 8'd3, timer_t'($urandom_range(2, 254)), HOLD_RESET};

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// opening requests under the reset hold time
		send_request(FUNC_TICK, TAB_BATTERY, '0);
		send_request(FUNC_REPORT, TAB_INVALID, 32'hDEAD_BEEF);
		send_request(FUNC_REPORT, TAB_BATTERY, 32'hFFFF_FFFF);
		send_request(FUNC_REPORT, TAB_BATTERY, '0);
		send_request(FUNC_REPORT, TAB_MOTOR, 32'h0000_0001);
		send_request(FUNC_REPORT, TAB_BATTERY, 32'hFFFF_FFFF);
		// one more code than the table holds
		for (int i = 0; i < SLOTS_PER_TABLE + 1; i++)
			send_request(FUNC_REPORT, TAB_OTHER, code_t'(32'h8000_0000 >> i) | 32'h0000_00F0);
		send_request(FUNC_TICK, TAB_INVALID, 32'hFFFF_FFFF);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_hold(hold_plan[p]);
			if (p == 1) begin
				long_hold_asks++;
				send_request(FUNC_TICK, TAB_BATTERY, '0);
			end
			burst_left = $urandom_range(1, 12);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				send_random_item(code_pool);
				burst_left--;
				if (burst_left == 0) begin
					idle_sender($urandom_range(1, 8));
					burst_left = $urandom_range(1, 12);
				end
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("aging_fault_code_table_top verification clean");
		else
			$display("aging_fault_code_table_top verification failed");
		$finish;
	end

endmodule
